// File: hw/rtl/gdrc_pkg.sv
// ----------------------------------------------------------------------------
// gdrc_pkg: shared constants for the grid DDA ray caster
// Grid size, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdrc_pkg;

    // grid geometry
    localparam int GRID_W   = 32;
    localparam int GRID_H   = 32;
    localparam int GRID_MAX = (GRID_W > GRID_H) ? GRID_W : GRID_H;
    localparam int CELLS    = GRID_W * GRID_H;
    localparam int ADDR_W   = $clog2(CELLS);
    // signed cell coordinate, room for one step past either edge
    localparam int CRD_W    = $clog2(GRID_MAX) + 2;
    // DDA walk length limit
    localparam int MAX_STEPS = GRID_W + GRID_H + 2;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    // datapath widths
    localparam int POS_W   = 15;
    localparam int VEC_W   = 16;
    localparam int SW_W    = 13;
    localparam int COL_W   = 12;
    localparam int FRAC_W  = 10;
    localparam int QUO_W   = 31;   // divider quotient bits
    localparam int DIVR_W  = 32;   // divisor bits
    localparam int CAM_W   = 28;
    localparam int RAY_W   = 32;
    localparam int DLT_W   = 32;
    localparam int SIDE_W  = 41;
    localparam int MA_W    = 17;
    localparam int MB_W    = 33;
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [DLT_W-1:0] DELTA_SAT = '1;
    localparam int ONE_Q14 = 16384;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5,
        REG_SCR_W   = 3'd6
    } t_reg_idx;

endpackage

`default_nettype wire

// File: hw/rtl/gdrc_ram.sv
// ----------------------------------------------------------------------------
// gdrc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/grid_dda_ray_caster_core.sv
// ----------------------------------------------------------------------------
// grid_dda_ray_caster_core: wall grid plus DDA ray caster for screen columns
//
// Input stream (s_axis): tuser = 0 writes one wall bit of the 32x32 grid,
// tuser = 1 casts the ray of one screen column. Output stream (m_axis)
// carries one result transfer per cast; a map write gives none.
// Config channel: register index and data, always ready, write only while
// the block is idle.
// Sequence: a map write goes into the wall RAM as it is accepted. A cast runs
// one shared restoring divider three times (column scale and two reciprocals),
// one shared multiplier four times, then a step state and a wall RAM read
// state per grid step. One item is worked at a time; s_axis_tready is low
// meanwhile.
// Reset: registers take their reset values and the wall RAM is cleared by
// a pass over all 1024 cells, one cell per cycle, with s_axis_tready low.
// Stall: the result sits in an output register; a new item is accepted
// while it waits, and a cast finishing before it is taken holds until the
// register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_dda_ray_caster_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] column, [16:12] cell_x, [21:17] cell_y, [22] cell_is_wall, [23] zero
    input  wire  [23:0] s_axis_tdata,
    // [0] req_type
    input  wire  [0:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [11:0] out_column, [16:12] hit_x, [21:17] hit_y, [22] hit_side,
    // [23] step_x_neg, [24] step_y_neg, [25] missed, [31:26] zero
    output logic [31:0] m_axis_tdata,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int AW = gdrc_pkg::ADDR_W;
    localparam int CW = gdrc_pkg::CRD_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_CAM,
        ST_MUL_RX,
        ST_MUL_RY,
        ST_SUM_RY,
        ST_DIV_DX,
        ST_DIV_DY,
        ST_MUL_SX,
        ST_MUL_SY,
        ST_SUM_SY,
        ST_STEP,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [gdrc_pkg::POS_W-1:0]        r_pos_x, r_pos_y;
    logic signed [gdrc_pkg::VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [gdrc_pkg::SW_W-1:0]         r_scr_w;

    // cast working registers
    logic [AW-1:0]                      r_clr;
    logic [gdrc_pkg::COL_W-1:0]         r_col;
    logic signed [gdrc_pkg::CAM_W-1:0]  r_cam;
    logic signed [gdrc_pkg::RAY_W-1:0]  r_rx, r_ry;
    logic [gdrc_pkg::DLT_W-1:0]         r_dx, r_dy;
    logic [gdrc_pkg::SIDE_W-1:0]        r_sx, r_sy;
    logic signed [CW-1:0]               r_mx, r_my;
    logic                               r_side, r_missed;
    logic [gdrc_pkg::CNT_W-1:0]         r_cnt;
    logic signed [gdrc_pkg::PROD_W-1:0] r_prod;

    // divider registers
    logic [gdrc_pkg::DIVR_W-1:0] r_rem, r_div;
    logic [gdrc_pkg::QUO_W-1:0]  r_quo;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // input fields
    logic                       w_req_cast;
    logic [gdrc_pkg::COL_W-1:0] w_column;
    logic [4:0]                 w_cell_x, w_cell_y;
    logic                       w_cell_wall;

    assign w_req_cast  = s_axis_tuser[0];
    assign w_column    = s_axis_tdata[11:0];
    assign w_cell_x    = s_axis_tdata[16:12];
    assign w_cell_y    = s_axis_tdata[21:17];
    assign w_cell_wall = s_axis_tdata[22];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    logic w_in_xfer;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // shared restoring divider step
    logic [gdrc_pkg::DIVR_W:0]   n_shift;
    logic [gdrc_pkg::DIVR_W+1:0] n_trial;
    logic                        n_ge;
    logic [gdrc_pkg::DIVR_W-1:0] n_rem;
    logic [gdrc_pkg::QUO_W-1:0]  n_quo;
    logic                        w_div_last;

    always_comb begin
        n_shift = {r_rem, r_quo[gdrc_pkg::QUO_W-1]};
        n_trial = {1'b0, n_shift} - {2'b00, r_div};
        n_ge    = !n_trial[gdrc_pkg::DIVR_W+1];
        n_rem   = n_ge ? n_trial[gdrc_pkg::DIVR_W-1:0] : n_shift[gdrc_pkg::DIVR_W-1:0];
        n_quo   = {r_quo[gdrc_pkg::QUO_W-2:0], n_ge};
    end
    assign w_div_last = (r_cnt == gdrc_pkg::CNT_W'(gdrc_pkg::QUO_W - 1));

    // divisor sources
    logic [gdrc_pkg::DIVR_W-1:0] w_sw_div, w_abs_rx, w_abs_ry;
    assign w_sw_div = (r_scr_w == '0) ? gdrc_pkg::DIVR_W'(1) : gdrc_pkg::DIVR_W'(r_scr_w);
    assign w_abs_rx = r_rx[gdrc_pkg::RAY_W-1] ? gdrc_pkg::DIVR_W'(-r_rx)
                                              : gdrc_pkg::DIVR_W'(r_rx);
    assign w_abs_ry = r_ry[gdrc_pkg::RAY_W-1] ? gdrc_pkg::DIVR_W'(-r_ry)
                                              : gdrc_pkg::DIVR_W'(r_ry);

    // reciprocal delta, saturated for a zero component
    logic [gdrc_pkg::DLT_W-1:0] w_delta;
    assign w_delta = {1'b0, n_quo};

    // side distance start fractions
    logic w_nx, w_ny;
    logic [gdrc_pkg::FRAC_W:0] w_fsx, w_fsy;
    assign w_nx  = r_rx[gdrc_pkg::RAY_W-1];
    assign w_ny  = r_ry[gdrc_pkg::RAY_W-1];
    assign w_fsx = w_nx ? {1'b0, r_pos_x[gdrc_pkg::FRAC_W-1:0]}
                        : (11'd1024 - {1'b0, r_pos_x[gdrc_pkg::FRAC_W-1:0]});
    assign w_fsy = w_ny ? {1'b0, r_pos_y[gdrc_pkg::FRAC_W-1:0]}
                        : (11'd1024 - {1'b0, r_pos_y[gdrc_pkg::FRAC_W-1:0]});

    // shared multiplier operand select
    logic signed [gdrc_pkg::MA_W-1:0] w_ma;
    logic signed [gdrc_pkg::MB_W-1:0] w_mb;

    always_comb begin
        case (r_state)
            ST_MUL_RX: begin
                w_ma = gdrc_pkg::MA_W'(r_plane_x);
                w_mb = gdrc_pkg::MB_W'(r_cam);
            end
            ST_MUL_RY: begin
                w_ma = gdrc_pkg::MA_W'(r_plane_y);
                w_mb = gdrc_pkg::MB_W'(r_cam);
            end
            ST_MUL_SX: begin
                w_ma = signed'(gdrc_pkg::MA_W'(w_fsx));
                w_mb = signed'({1'b0, r_dx});
            end
            ST_MUL_SY: begin
                w_ma = signed'(gdrc_pkg::MA_W'(w_fsy));
                w_mb = signed'({1'b0, r_dy});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // ray component from registered product, floor by arithmetic shift
    logic signed [gdrc_pkg::RAY_W-1:0] w_ray_sum;
    logic signed [gdrc_pkg::RAY_W-1:0] w_dir_sel;
    assign w_dir_sel = (r_state == ST_MUL_RY) ? gdrc_pkg::RAY_W'(r_dir_x)
                                              : gdrc_pkg::RAY_W'(r_dir_y);
    assign w_ray_sum = w_dir_sel + signed'(r_prod[gdrc_pkg::RAY_W+13:14]);

    // side distance from registered product
    logic [gdrc_pkg::SIDE_W-1:0] w_side0;
    assign w_side0 = gdrc_pkg::SIDE_W'(r_prod[gdrc_pkg::PROD_W-2:gdrc_pkg::FRAC_W]);

    // player cell
    logic signed [CW-1:0] w_px, w_py;
    logic                 w_p_out;
    assign w_px = signed'(CW'(r_pos_x[gdrc_pkg::POS_W-1:gdrc_pkg::FRAC_W]));
    assign w_py = signed'(CW'(r_pos_y[gdrc_pkg::POS_W-1:gdrc_pkg::FRAC_W]));
    assign w_p_out = (w_px >= CW'(gdrc_pkg::GRID_W)) || (w_py >= CW'(gdrc_pkg::GRID_H));

    // one DDA step
    logic                 n_step_x;
    logic signed [CW-1:0] n_mx, n_my;
    logic                 n_out;

    always_comb begin
        n_step_x = (r_sx < r_sy);
        n_mx = r_mx;
        n_my = r_my;
        if (n_step_x) begin
            n_mx = w_nx ? (r_mx - CW'(1)) : (r_mx + CW'(1));
        end else begin
            n_my = w_ny ? (r_my - CW'(1)) : (r_my + CW'(1));
        end
        n_out = (n_mx < 0) || (n_my < 0) ||
                (n_mx >= CW'(gdrc_pkg::GRID_W)) || (n_my >= CW'(gdrc_pkg::GRID_H));
    end

    // wall RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          w_wdata, w_rdata;
    logic          w_wr_in_grid;

    assign w_wr_in_grid = (32'(w_cell_x) < gdrc_pkg::GRID_W) &&
                          (32'(w_cell_y) < gdrc_pkg::GRID_H);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 1'b0;
        end else begin
            w_we    = w_in_xfer && !w_req_cast && w_wr_in_grid;
            w_waddr = AW'(w_cell_y) * AW'(gdrc_pkg::GRID_W) + AW'(w_cell_x);
            w_wdata = w_cell_wall;
        end
    end
    assign w_raddr = AW'(n_my) * AW'(gdrc_pkg::GRID_W) + AW'(n_mx);

    gdrc_ram #(
        .WIDTH (1),
        .DEPTH (gdrc_pkg::CELLS)
    ) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result word
    logic [31:0] w_result;
    assign w_result = {6'd0, r_missed, w_ny, w_nx,
                       r_missed ? 1'b0 : r_side,
                       r_missed ? 5'd0 : 5'(r_my),
                       r_missed ? 5'd0 : 5'(r_mx),
                       r_col};

    // multiplier product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // sequencer, datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pos_x     <= 15'd2048;
            r_pos_y     <= 15'd2048;
            r_dir_x     <= -16'sd16384;
            r_dir_y     <= 16'sd0;
            r_plane_x   <= 16'sd0;
            r_plane_y   <= 16'sd10813;
            r_scr_w     <= 13'd640;
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                case (gdrc_pkg::t_reg_idx'(i_cfg_index))
                    gdrc_pkg::REG_POS_X:   r_pos_x   <= i_cfg_data[gdrc_pkg::POS_W-1:0];
                    gdrc_pkg::REG_POS_Y:   r_pos_y   <= i_cfg_data[gdrc_pkg::POS_W-1:0];
                    gdrc_pkg::REG_DIR_X:   r_dir_x   <= signed'(i_cfg_data);
                    gdrc_pkg::REG_DIR_Y:   r_dir_y   <= signed'(i_cfg_data);
                    gdrc_pkg::REG_PLANE_X: r_plane_x <= signed'(i_cfg_data);
                    gdrc_pkg::REG_PLANE_Y: r_plane_y <= signed'(i_cfg_data);
                    gdrc_pkg::REG_SCR_W:   r_scr_w   <= i_cfg_data[gdrc_pkg::SW_W-1:0];
                    default: ;
                endcase
            end

            // result taken downstream; a finishing cast reloads it below
            if (r_out_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(gdrc_pkg::CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_xfer && w_req_cast) begin
                        // column scale: (column << 15) / width
                        r_col   <= w_column;
                        r_rem   <= '0;
                        r_quo   <= gdrc_pkg::QUO_W'({w_column, 15'd0});
                        r_div   <= w_sw_div;
                        r_cnt   <= '0;
                        r_state <= ST_DIV_CAM;
                    end
                end
                ST_DIV_CAM: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + gdrc_pkg::CNT_W'(1);
                    if (w_div_last) begin
                        r_cam   <= signed'(gdrc_pkg::CAM_W'(n_quo)) -
                                   gdrc_pkg::CAM_W'(gdrc_pkg::ONE_Q14);
                        r_state <= ST_MUL_RX;
                    end
                end
                ST_MUL_RX: begin
                    r_state <= ST_MUL_RY;
                end
                ST_MUL_RY: begin
                    r_rx    <= w_ray_sum;
                    r_state <= ST_SUM_RY;
                end
                ST_SUM_RY: begin
                    r_ry    <= w_ray_sum;
                    // reciprocal of |rx|
                    r_rem   <= '0;
                    r_quo   <= gdrc_pkg::QUO_W'(1 << 30);
                    r_div   <= w_abs_rx;
                    r_cnt   <= '0;
                    r_state <= ST_DIV_DX;
                end
                ST_DIV_DX: begin
                    if (w_div_last) begin
                        r_dx    <= (r_rx == '0) ? gdrc_pkg::DELTA_SAT : w_delta;
                        // reciprocal of |ry|
                        r_rem   <= '0;
                        r_quo   <= gdrc_pkg::QUO_W'(1 << 30);
                        r_div   <= w_abs_ry;
                        r_cnt   <= '0;
                        r_state <= ST_DIV_DY;
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= n_quo;
                        r_cnt <= r_cnt + gdrc_pkg::CNT_W'(1);
                    end
                end
                ST_DIV_DY: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + gdrc_pkg::CNT_W'(1);
                    if (w_div_last) begin
                        r_dy    <= (r_ry == '0) ? gdrc_pkg::DELTA_SAT : w_delta;
                        r_state <= ST_MUL_SX;
                    end
                end
                ST_MUL_SX: begin
                    r_state <= ST_MUL_SY;
                end
                ST_MUL_SY: begin
                    r_sx    <= w_side0;
                    r_state <= ST_SUM_SY;
                end
                ST_SUM_SY: begin
                    r_sy     <= w_side0;
                    r_mx     <= w_px;
                    r_my     <= w_py;
                    r_side   <= 1'b0;
                    r_cnt    <= '0;
                    r_missed <= 1'b1;
                    r_state  <= w_p_out ? ST_DONE : ST_STEP;
                end
                ST_STEP: begin
                    // advance one cell; wall bit read issued for the new cell
                    if (n_step_x) begin
                        r_sx   <= r_sx + gdrc_pkg::SIDE_W'(r_dx);
                        r_side <= 1'b0;
                    end else begin
                        r_sy   <= r_sy + gdrc_pkg::SIDE_W'(r_dy);
                        r_side <= 1'b1;
                    end
                    r_mx    <= n_mx;
                    r_my    <= n_my;
                    r_cnt   <= r_cnt + gdrc_pkg::CNT_W'(1);
                    r_state <= n_out ? ST_DONE : ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_rdata) begin
                        r_missed <= 1'b0;
                        r_state  <= ST_DONE;
                    end else if (r_cnt == gdrc_pkg::CNT_W'(gdrc_pkg::MAX_STEPS)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_STEP;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_result;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: tb/grid_dda_ray_caster_core_test.sv
// ----------------------------------------------------------------------------
// grid_dda_ray_caster_core_test: self-checking bench for the DDA ray caster
// Drives map writes and casts over the input stream, predicts untyped cast
// results from a local copy of the wall grid and registers, and checks the
// result stream under random idling, a long output stall and config phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_dda_ray_caster_core_test;

    localparam int WDOG_LIMIT = 3000;
    localparam int IDLE_WAIT  = 300;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_LEN  = 205;
    localparam int NUM_PHASES = 8;

    typedef enum logic { REQ_WRITE = 1'b0, REQ_CAST = 1'b1 } t_req;

    // one directed row; typed result only where it is obvious
    typedef struct {
        t_req        kind;
        logic [11:0] column;
        logic [4:0]  cx;
        logic [4:0]  cy;
        logic        wall;
        bit          typed;
        logic [31:0] result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    grid_dda_ray_caster_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // local copy of the block state
    bit                 wall_map [0:31][0:31];
    logic [14:0]        pos_x, pos_y;
    logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
    logic [12:0]        scr_w;

    logic [31:0] hit_q [$];
    int          errors;
    int          idle_cycles;
    bit          hold_req;
    bit          no_gap;
    bit          cur_typed;
    logic [31:0] cur_result;

    // DDA walk for one column; returns the packed result word
    function automatic logic [31:0] cast_ray(logic [11:0] col);
        longint          cam, rx, ry, mx, my;
        longint unsigned sw, dx, dy, sx, sy, fx, fy;
        bit              nx, ny, miss, side;
        sw   = (scr_w == 0) ? 1 : scr_w;
        cam  = longint'(((64'(col) * 2) << 14) / sw) - gdrc_pkg::ONE_Q14;
        rx   = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 14);
        ry   = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 14);
        dx   = (rx == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / ((rx < 0) ? -rx : rx);
        dy   = (ry == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / ((ry < 0) ? -ry : ry);
        nx   = rx < 0;
        ny   = ry < 0;
        mx   = pos_x >> 10;
        my   = pos_y >> 10;
        fx   = pos_x & 1023;
        fy   = pos_y & 1023;
        sx   = ((nx ? fx : 1024 - fx) * dx) >> 10;
        sy   = ((ny ? fy : 1024 - fy) * dy) >> 10;
        miss = 1'b1;
        side = 1'b0;
        for (int n = 0; n < gdrc_pkg::MAX_STEPS; n++) begin
            if (sx < sy) begin
                sx += dx; mx += nx ? -1 : 1; side = 1'b0;
            end else begin
                sy += dy; my += ny ? -1 : 1; side = 1'b1;
            end
            if (mx < 0 || my < 0 || mx >= gdrc_pkg::GRID_W || my >= gdrc_pkg::GRID_H) break;
            if (wall_map[my][mx]) begin
                miss = 1'b0;
                break;
            end
        end
        if (miss) return {6'd0, 1'b1, ny, nx, 1'b0, 5'd0, 5'd0, col};
        return {6'd0, 1'b0, ny, nx, side, 5'(my), 5'(mx), col};
    endfunction

    // input transfers: update grid or queue the expected hit
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser[0] == REQ_CAST)
                hit_q.push_back(cur_typed ? cur_result : cast_ray(s_axis_tdata[11:0]));
            else
                wall_map[s_axis_tdata[21:17]][s_axis_tdata[16:12]] = s_axis_tdata[22];
        end
    end

    // result transfers: compare field by field with the oldest expectation
    always @(posedge i_clk) begin
        logic [31:0] exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_w = hit_q.pop_front();
                if (exp_w[11:0] !== m_axis_tdata[11:0] || exp_w[16:12] !== m_axis_tdata[16:12]
                    || exp_w[21:17] !== m_axis_tdata[21:17] || exp_w[22] !== m_axis_tdata[22]
                    || exp_w[23] !== m_axis_tdata[23] || exp_w[24] !== m_axis_tdata[24]
                    || exp_w[25] !== m_axis_tdata[25] || m_axis_tdata[31:26] !== 6'd0) begin
                    $display("%0t: mismatch expected col=%0d hit=(%0d,%0d) side=%0d sx=%0d sy=%0d miss=%0d",
                             $time, exp_w[11:0], exp_w[16:12], exp_w[21:17], exp_w[22],
                             exp_w[23], exp_w[24], exp_w[25]);
                    $display("%0t:          actual col=%0d hit=(%0d,%0d) side=%0d sx=%0d sy=%0d miss=%0d",
                             $time, m_axis_tdata[11:0], m_axis_tdata[16:12], m_axis_tdata[21:17],
                             m_axis_tdata[22], m_axis_tdata[23], m_axis_tdata[24],
                             m_axis_tdata[25]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = no_gap ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // offer one item after a random gap and wait for its transfer
    task automatic send_item(t_req kind, logic [23:0] data, bit typed, logic [31:0] result);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        cur_typed     = typed;
        cur_result    = result;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(gdrc_pkg::t_reg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gdrc_pkg::REG_POS_X:   pos_x   = value[14:0];
            gdrc_pkg::REG_POS_Y:   pos_y   = value[14:0];
            gdrc_pkg::REG_DIR_X:   dir_x   = value;
            gdrc_pkg::REG_DIR_Y:   dir_y   = value;
            gdrc_pkg::REG_PLANE_X: plane_x = value;
            gdrc_pkg::REG_PLANE_Y: plane_y = value;
            gdrc_pkg::REG_SCR_W:   scr_w   = value[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let a trailing map write settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [15:0] px, logic [15:0] py, logic [15:0] dx_v,
                             logic [15:0] dy_v, logic [15:0] plx, logic [15:0] ply,
                             logic [15:0] sw);
        write_reg(gdrc_pkg::REG_POS_X, px);
        write_reg(gdrc_pkg::REG_POS_Y, py);
        write_reg(gdrc_pkg::REG_DIR_X, dx_v);
        write_reg(gdrc_pkg::REG_DIR_Y, dy_v);
        write_reg(gdrc_pkg::REG_PLANE_X, plx);
        write_reg(gdrc_pkg::REG_PLANE_Y, ply);
        write_reg(gdrc_pkg::REG_SCR_W, sw);
    endtask

    t_row rows [] = '{
        // empty grid after reset, straight ray along -x
        '{REQ_CAST,  12'd320,  5'd0,  5'd0,  1'b0, 1'b1, {6'd0, 3'b101, 1'b0, 10'd0, 12'd320}},
        '{REQ_WRITE, 12'hFFF,  5'd0,  5'd2,  1'b1, 1'b0, 32'd0},
        '{REQ_CAST,  12'd320,  5'd0,  5'd0,  1'b0, 1'b1, {6'd0, 3'b001, 1'b0, 5'd2, 5'd0, 12'd320}},
        '{REQ_CAST,  12'd0,    5'd31, 5'd31, 1'b1, 1'b0, 32'd0},
        '{REQ_CAST,  12'd639,  5'd0,  5'd0,  1'b0, 1'b0, 32'd0},
        '{REQ_CAST,  12'd4095, 5'd0,  5'd0,  1'b0, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd31, 5'd31, 1'b1, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd31, 5'd0,  1'b1, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd0,  5'd31, 1'b1, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd0,  5'd2,  1'b0, 1'b0, 32'd0},
        '{REQ_CAST,  12'd0,    5'd0,  5'd0,  1'b0, 1'b0, 32'd0},
        '{REQ_CAST,  12'd640,  5'd0,  5'd0,  1'b0, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd5,  5'd2,  1'b1, 1'b0, 32'd0},
        '{REQ_CAST,  12'd320,  5'd0,  5'd0,  1'b0, 1'b0, 32'd0},
        '{REQ_WRITE, 12'd0,    5'd1,  5'd0,  1'b1, 1'b0, 32'd0},
        '{REQ_CAST,  12'd100,  5'd0,  5'd0,  1'b0, 1'b0, 32'd0}
    };

    initial begin
        logic [23:0] data;
        int          pct;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = gdrc_pkg::REG_POS_X;
        i_cfg_data    = '0;
        errors        = 0;
        idle_cycles   = 0;
        hold_req      = 1'b0;
        no_gap        = 1'b0;
        cur_typed     = 1'b0;
        cur_result    = '0;
        pos_x = 15'd2048; pos_y = 15'd2048;
        dir_x = -16'sd16384; dir_y = 16'sd0;
        plane_x = 16'sd0; plane_y = 16'sd10813;
        scr_w = 13'd640;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at reset settings
        foreach (rows[i])
            send_item(rows[i].kind, {rows[i].wall, rows[i].cy, rows[i].cx, rows[i].column},
                      rows[i].typed, rows[i].result);
        drain();

        // random phases, each with its own register set
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: load_regs(16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
                2: load_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd1);
                3: load_regs(16'd16896, 16'd16896, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4096);
                4: load_regs(16'd8704, 16'd20992, 16'd0, 16'd16384, 16'd10813, 16'd0, 16'd8191);
                default: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(1, 4096));
            endcase
            no_gap = (ph == 3);
            if (ph == 2) hold_req = 1'b1;
            // sparse grids early, denser ones later
            pct = 10 + 6 * ph;
            for (int n = 0; n < PHASE_LEN; n++) begin
                data = $urandom;
                // pad bit stays zero
                data[23] = 1'b0;
                if ($urandom_range(0, 99) < 35) begin
                    data[22] = ($urandom_range(0, 99) < pct);
                    send_item(REQ_WRITE, data, 1'b0, 32'd0);
                end else begin
                    send_item(REQ_CAST, data, 1'b0, 32'd0);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
